@@ rtl/dea_pkg.sv @@
// ----------------------------------------------------------------------------
// dea_pkg
// shared widths, request and status codes, controller command type
// ----------------------------------------------------------------------------
package dea_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int DATA_W    = 32;
    localparam int ACT_W     = 3;
    localparam int ST_W      = 3;
    localparam int CAP_W     = 9;

    // request codes
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_REAR  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_REAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PEEK_REAR  = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_FRONT = 3'd3;
    localparam logic [ST_W-1:0] ST_NO_REAR  = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic exec;      // run the accepted request this cycle
        logic cfg_load;  // take a new capacity and empty the deque
    } dea_cmd_t;

endpackage

@@ rtl/dea_ctrl.sv @@
// ----------------------------------------------------------------------------
// dea_ctrl
// two-state sequencer: accept a request, then present its result
// ----------------------------------------------------------------------------
module dea_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_valid,
    output logic              busy,
    output logic              cfg_ready,
    output logic              done,
    output dea_pkg::dea_cmd_t cmd
);
    import dea_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // a request wins over a capacity write in the same cycle
    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE) && !start;
    assign done         = (state_reg == S_RESP);
    assign cmd.exec     = start && (state_reg == S_IDLE);
    assign cmd.cfg_load = cfg_valid && cfg_ready;

    a_exec_then_done : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> done)
        else $error("result strobe missing after accepted request");

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.cfg_load))
        else $error("request and capacity write in the same cycle");

endmodule

@@ rtl/dea_datapath.sv @@
// ----------------------------------------------------------------------------
// dea_datapath
// head and tail indices, capacity register, storage array, result registers
// ----------------------------------------------------------------------------
module dea_datapath
#(
    parameter int DEPTH = dea_pkg::DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  dea_pkg::dea_cmd_t                  cmd,
    input  logic [dea_pkg::ACT_W-1:0]          action,
    input  logic signed [dea_pkg::DATA_W-1:0]  value,
    input  logic [dea_pkg::CAP_W-1:0]          cfg_data,
    output logic signed [dea_pkg::DATA_W-1:0]  data,
    output logic [dea_pkg::ST_W-1:0]           status,
    output logic                               is_empty,
    output logic                               is_full
);
    import dea_pkg::*;

    localparam int IW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = (IW > CAP_W) ? IW : CAP_W;

    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic [IW-1:0] cap_reg, cap_next;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_ok_reg, rd_ok_next;
    logic [ST_W-1:0]          status_reg, status_next;
    logic                     empty_reg, full_reg;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          empty_now, full_now;
    logic [IW-1:0] head_inc, tail_dec;
    logic [CW-1:0] cfg_ext;

    assign empty_now = (head_reg == tail_reg);
    assign full_now  = (head_reg == '0) && (tail_reg == cap_reg);
    assign head_inc  = head_reg + IW'(1);
    assign tail_dec  = tail_reg - IW'(1);
    assign cfg_ext   = CW'(cfg_data);

    // clamp written capacity into 1..DEPTH
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            cap_next = IW'(1);
        end
        else if (cfg_ext > CW'(DEPTH))
        begin
            cap_next = IW'(DEPTH);
        end
        else
        begin
            cap_next = cfg_ext[IW-1:0];
        end
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        status_next = ST_OK;
        rd_ok_next  = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = tail_reg[AW-1:0];
        rd_addr     = head_reg[AW-1:0];
        case (action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR:
            begin
                if (full_now)
                begin
                    status_next = ST_FULL;
                end
                else if (action == ACT_PUSH_FRONT)
                begin
                    if (head_reg == '0)
                    begin
                        status_next = ST_NO_FRONT;
                    end
                    else
                    begin
                        head_next = head_reg - IW'(1);
                        wr_en     = 1'b1;
                        wr_addr   = head_next[AW-1:0];
                    end
                end
                else
                begin
                    if (tail_reg >= cap_reg)
                    begin
                        status_next = ST_NO_REAR;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = tail_reg[AW-1:0];
                        tail_next = tail_reg + IW'(1);
                    end
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR:
            begin
                if (empty_now)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_ok_next = 1'b1;
                    if (action == ACT_POP_FRONT || action == ACT_PEEK_FRONT)
                    begin
                        rd_addr = head_reg[AW-1:0];
                        if (action == ACT_POP_FRONT)
                        begin
                            head_next = head_inc;
                        end
                    end
                    else
                    begin
                        rd_addr = tail_dec[AW-1:0];
                        if (action == ACT_POP_REAR)
                        begin
                            tail_next = tail_dec;
                        end
                    end
                    // indices meet after a pop: return both to zero
                    if (head_next == tail_next)
                    begin
                        head_next = '0;
                        tail_next = '0;
                    end
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            cap_reg    <= IW'(DEPTH);
            rd_ok_reg  <= 1'b0;
            status_reg <= ST_OK;
            empty_reg  <= 1'b1;
            full_reg   <= 1'b0;
        end
        else if (cmd.cfg_load)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cap_reg  <= cap_next;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            rd_ok_reg  <= rd_ok_next;
            status_reg <= status_next;
            empty_reg  <= (head_next == tail_next);
            full_reg   <= (head_next == '0) && (tail_next == cap_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (cmd.exec && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign data     = rd_ok_reg ? rd_data_reg : '0;
    assign status   = status_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

    a_head_le_tail : assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head index passed tail index");

    a_tail_le_cap : assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= cap_reg)
        else $error("tail index beyond capacity");

    a_cap_range : assert property (@(posedge clk) disable iff (!rst_n)
        (cap_reg != '0) && (cap_reg <= IW'(DEPTH)))
        else $error("capacity out of range");

endmodule

@@ rtl/double_ended_queue_array.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_array
// flat-array deque with push, pop and peek at either end
// ----------------------------------------------------------------------------
// usage
//   request channel: drive action and value with start; the transaction is
//     taken at a rising edge with start high and busy low
//   result channel: done is high for exactly one cycle, in the cycle after the
//     request was taken, with data, status, is_empty and is_full valid; the
//     receiver cannot stall, so it must capture the result in that cycle
//   capacity channel: cfg_valid / cfg_ready, cfg_data is the new capacity;
//     the write clamps into 1..DEPTH and empties the deque
// flow
//   a request is taken only in the idle state, and busy covers the result
//   cycle, so no new request is taken while a result is presented
// reset
//   rst_n is asynchronous active low: indices to zero, capacity to DEPTH;
//   storage content is not cleared, only pushed words are ever read back
// ----------------------------------------------------------------------------
module double_ended_queue_array
#(
    parameter int DEPTH = dea_pkg::DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  logic [dea_pkg::ACT_W-1:0]          action,
    input  logic signed [dea_pkg::DATA_W-1:0]  value,
    // result channel
    output logic                               done,
    output logic signed [dea_pkg::DATA_W-1:0]  data,
    output logic [dea_pkg::ST_W-1:0]           status,
    output logic                               is_empty,
    output logic                               is_full,
    // capacity write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dea_pkg::CAP_W-1:0]          cfg_data
);
    import dea_pkg::*;

    // command bundle from sequencer to datapath
    dea_cmd_t cmd;

    // sequencer: idle -> result cycle -> idle
    dea_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .cmd       (cmd)
    );

    // indices, storage array and result registers
    dea_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .action   (action),
        .value    (value),
        .cfg_data (cfg_data),
        .data     (data),
        .status   (status),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

endmodule

@@ bench/double_ended_queue_array_tb.sv @@
// ============================================================================
// double_ended_queue_array_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the flat-array deque. A shadow copy of the head,
// tail, capacity and storage works out the expected word, status and flags
// for every request taken by the block. Each strobed result is compared
// with the oldest outstanding expectation. Stimulus runs in this order:
// empty-deque and unused-code requests, boundary cases at capacities 1 and
// 2, a full-depth fill and drain, then random phases at random capacities.
// ============================================================================
module double_ended_queue_array_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dea_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int STALL_LIMIT = 1000;   // cycles with no transaction at all
    localparam int DRAIN_WAIT  = 4;      // settle time after the last result

    // request codes the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_UNUSED_B = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [ST_W-1:0]          status;
        logic                     is_empty;
        logic                     is_full;
    } deque_result_t;

    // dut ports
    logic                     clk;
    logic                     rst_n     = 1'b0;
    logic                     start     = 1'b0;
    logic                     busy;
    logic [ACT_W-1:0]         action    = '0;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     done;
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic                     is_empty;
    logic                     is_full;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CAP_W-1:0]         cfg_data  = '0;

    // shadow deque state
    logic signed [DATA_W-1:0] sh_mem [DEPTH];
    int unsigned              sh_head = 0;
    int unsigned              sh_tail = 0;
    int unsigned              sh_cap  = DEPTH;

    // results still owed by the block, oldest first
    deque_result_t awaited_results [$];

    // bookkeeping
    int  fail_count    = 0;
    int  requests_sent = 0;
    int  cap_writes    = 0;
    int  results_seen  = 0;
    int  deepest_fill  = 0;
    int  status_hits [5];
    int  idle_cycles   = 0;
    bit  no_gaps       = 1'b0;   // set for a stretch with back-to-back requests

    double_ended_queue_array #(
        .DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .value     (value),
        .done      (done),
        .data      (data),
        .status    (status),
        .is_empty  (is_empty),
        .is_full   (is_full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // shadow deque: update on every accepted request, queue the outcome
    // ------------------------------------------------------------------------
    task automatic apply_request(input logic [ACT_W-1:0] act,
                                 input logic signed [DATA_W-1:0] val);
        deque_result_t res;
        bit            was_empty;
        bit            was_full;
        was_empty  = (sh_head == sh_tail);
        was_full   = (sh_head == 0 && sh_tail == sh_cap);
        res.data   = '0;
        res.status = ST_OK;
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_REAR:
            begin
                // full check wins over the end-specific checks
                if (was_full)
                    res.status = ST_FULL;
                else if (act == ACT_PUSH_FRONT)
                begin
                    if (sh_head == 0)
                        res.status = ST_NO_FRONT;
                    else
                    begin
                        sh_head--;
                        sh_mem[sh_head] = val;
                    end
                end
                else if (sh_tail >= sh_cap)
                    res.status = ST_NO_REAR;
                else
                begin
                    sh_mem[sh_tail] = val;
                    sh_tail++;
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR:
            begin
                if (was_empty)
                    res.status = ST_EMPTY;
                else if (act == ACT_POP_FRONT || act == ACT_PEEK_FRONT)
                begin
                    res.data = sh_mem[sh_head];
                    if (act == ACT_POP_FRONT)
                        sh_head++;
                end
                else
                begin
                    res.data = sh_mem[sh_tail - 1];
                    if (act == ACT_POP_REAR)
                        sh_tail--;
                end
                // indices meeting after a pop fold back to zero
                if (sh_head == sh_tail)
                begin
                    sh_head = 0;
                    sh_tail = 0;
                end
            end
            default: ;  // unused codes leave the deque alone
        endcase
        res.is_empty = (sh_head == sh_tail);
        res.is_full  = (sh_head == 0 && sh_tail == sh_cap);
        awaited_results.push_back(res);
        status_hits[res.status]++;
        if (int'(sh_tail - sh_head) > deepest_fill)
            deepest_fill = int'(sh_tail - sh_head);
    endtask

    // ------------------------------------------------------------------------
    // request driver: optional idle gap, then hold start until busy is low;
    // start stays high on return so back-to-back requests need no toggle
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [ACT_W-1:0] act,
                                input logic signed [DATA_W-1:0] val);
        while (!no_gaps && $urandom_range(99) < 24)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start  <= 1'b1;
        action <= act;
        value  <= val;
        do
            @(posedge clk);
        while (busy);
        requests_sent++;
        apply_request(act, val);
    endtask

    // ------------------------------------------------------------------------
    // capacity write: only once every outstanding result is back
    // ------------------------------------------------------------------------
    task automatic write_capacity(input logic [CAP_W-1:0] cap_word);
        int unsigned cap_eff;
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap_word;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cap_writes++;
        // zero reads as one, anything past the array reads as the array size
        cap_eff = 32'(cap_word);
        if (cap_eff == 0)
            cap_eff = 1;
        if (cap_eff > DEPTH)
            cap_eff = DEPTH;
        sh_cap  = cap_eff;
        sh_head = 0;
        sh_tail = 0;
    endtask

    // weighted request mix; fill phases lean on pushes, drain phases on pops
    function automatic logic [ACT_W-1:0] pick_action(input bit fill_phase);
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return ($urandom_range(1) != 0) ? ACT_UNUSED_A : ACT_UNUSED_B;
        if (fill_phase)
        begin
            if (r < 40) return ACT_PUSH_REAR;
            if (r < 60) return ACT_PUSH_FRONT;
            if (r < 75) return ACT_POP_FRONT;
            if (r < 85) return ACT_POP_REAR;
            if (r < 92) return ACT_PEEK_FRONT;
            return ACT_PEEK_REAR;
        end
        if (r < 15) return ACT_PUSH_REAR;
        if (r < 25) return ACT_PUSH_FRONT;
        if (r < 55) return ACT_POP_FRONT;
        if (r < 75) return ACT_POP_REAR;
        if (r < 85) return ACT_PEEK_FRONT;
        return ACT_PEEK_REAR;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // fresh deque at reset capacity: every read end is empty, no front room
    task automatic test_empty_and_unused();
        send_request(ACT_POP_FRONT,  $urandom);
        send_request(ACT_POP_REAR,   $urandom);
        send_request(ACT_PEEK_FRONT, $urandom);
        send_request(ACT_PEEK_REAR,  $urandom);
        send_request(ACT_PUSH_FRONT, 32'sh1234_5678);
        send_request(ACT_UNUSED_A,   $urandom);
        send_request(ACT_UNUSED_B,   $urandom);
    endtask

    // capacity clamping, full, no room at either end, indices meeting
    task automatic test_boundaries();
        write_capacity(9'd0);                        // taken as one entry
        send_request(ACT_PUSH_REAR,  32'sh8000_0000); // now full
        send_request(ACT_PUSH_REAR,  32'sh7fff_ffff); // full
        send_request(ACT_PUSH_FRONT, 32'sh7fff_ffff); // full beats no front
        send_request(ACT_PEEK_REAR,  $urandom);
        send_request(ACT_POP_FRONT,  $urandom);       // indices meet
        write_capacity(9'd2);
        send_request(ACT_PUSH_REAR,  -32'sd1);
        send_request(ACT_PUSH_REAR,  32'sh7fff_ffff);
        send_request(ACT_POP_FRONT,  $urandom);       // head 1, tail at cap
        send_request(ACT_PUSH_REAR,  32'sh0000_0000); // no room at rear
        send_request(ACT_PUSH_FRONT, 32'sh5555_5555); // refills the front
        send_request(ACT_PEEK_FRONT, $urandom);
        send_request(ACT_POP_REAR,   $urandom);
        send_request(ACT_POP_REAR,   $urandom);       // meet from the rear
        write_capacity(9'd511);                      // taken as the array size
    endtask

    // whole array filled back to back, then drained from both ends
    task automatic test_full_depth();
        write_capacity(CAP_W'(DEPTH));
        no_gaps = 1'b1;
        for (int i = 0; i < DEPTH; i++)
            send_request(ACT_PUSH_REAR, $urandom);
        send_request(ACT_PUSH_REAR,  $urandom);
        send_request(ACT_PUSH_FRONT, $urandom);
        send_request(ACT_PEEK_FRONT, $urandom);
        send_request(ACT_PEEK_REAR,  $urandom);
        no_gaps = 1'b0;
        for (int i = 0; i < DEPTH / 2; i++)
            send_request(ACT_POP_FRONT, $urandom);
        // room freed at the front, grow it back a little
        for (int i = 0; i < 16; i++)
            send_request(ACT_PUSH_FRONT, $urandom);
        while (sh_head != sh_tail)
        begin
            case ($urandom_range(9))
                0:       send_request(ACT_PEEK_FRONT, $urandom);
                1:       send_request(ACT_PEEK_REAR,  $urandom);
                2, 3, 4: send_request(ACT_POP_REAR,   $urandom);
                default: send_request(ACT_POP_FRONT,  $urandom);
            endcase
        end
    endtask

    // random capacities, mostly small, with fill and drain swings
    task automatic test_random_phases();
        logic [CAP_W-1:0] cap_word;
        for (int ph = 0; ph < 5; ph++)
        begin
            case ($urandom_range(9))
                0:       cap_word = '0;
                1:       cap_word = CAP_W'(DEPTH);
                2:       cap_word = CAP_W'($urandom_range(511, DEPTH + 1));
                3:       cap_word = CAP_W'($urandom_range(DEPTH - 1, 9));
                default: cap_word = CAP_W'($urandom_range(8, 1));
            endcase
            write_capacity(cap_word);
            for (int i = 0; i < 24; i++)
                send_request(pick_action(((i / 8) % 2) == 0), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // result checker: one transaction per done strobe, against oldest entry
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        deque_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result data=%0d status=%0d", $time, data, status);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (data !== want.data)
                begin
                    $display("%0t: data expected %0d got %0d", $time, want.data, data);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status, status);
                    fail_count++;
                end
                if (is_empty !== want.is_empty)
                begin
                    $display("%0t: is_empty expected %0b got %0b",
                             $time, want.is_empty, is_empty);
                    fail_count++;
                end
                if (is_full !== want.is_full)
                begin
                    $display("%0t: is_full expected %0b got %0b", $time, want.is_full, is_full);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: any request, result or capacity transaction clears the count
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_and_unused();
        test_boundaries();
        test_full_depth();
        test_random_phases();

        // let the last results come back, then a few quiet cycles
        start <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d requests, %0d capacity writes, %0d results, deepest fill %0d",
                 requests_sent, cap_writes, results_seen, deepest_fill);
        $display("status mix: ok %0d, full %0d, empty %0d, no front %0d, no rear %0d",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_NO_FRONT], status_hits[ST_NO_REAR]);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
